// ===== src/ipd_pkg.sv =====
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants for the IR pulse-distance decoder
// Holds reset values of the control registers, the command and response
// structs passed between the front, back and queues, and the key code table.
// ----------------------------------------------------------------------------
package ipd_pkg;

   // default widths
   localparam int INTERVAL_WIDTH_DEFAULT = 16;
   localparam int CODE_WIDTH_DEFAULT     = 32;

   // control register geometry
   localparam int CfgWidth   = 16;
   localparam int CountWidth = 6;
   localparam int FrameWidth = 32;
   localparam int KeyWidth   = 4;

   // queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // register reset values
   localparam logic [CfgWidth-1:0]   HEADER_MIN_RESET = 16'd13400;
   localparam logic [CfgWidth-1:0]   HEADER_MAX_RESET = 16'd13700;
   localparam logic [CfgWidth-1:0]   ZERO_MIN_RESET   = 16'd1100;
   localparam logic [CfgWidth-1:0]   ZERO_MAX_RESET   = 16'd1250;
   localparam logic [CfgWidth-1:0]   ONE_MIN_RESET    = 16'd2100;
   localparam logic [CfgWidth-1:0]   ONE_MAX_RESET    = 16'd2400;
   localparam logic [CountWidth-1:0] BITS_RESET       = 6'd32;

   // register indexes on the write port
   typedef enum logic [2:0] {
      REG_HEADER_MIN     = 3'd0,
      REG_HEADER_MAX     = 3'd1,
      REG_ZERO_MIN       = 3'd2,
      REG_ZERO_MAX       = 3'd3,
      REG_ONE_MIN        = 3'd4,
      REG_ONE_MAX        = 3'd5,
      REG_BITS_PER_FRAME = 3'd6
   } ipd_reg_type;

   // key table: digits 0-9, then last, mute, plus
   localparam int KeyCount = 13;
   localparam logic [KeyWidth-1:0] KEY_UNKNOWN = 4'd13;

   localparam logic [63:0] KEY_CODES [KeyCount] = '{
      64'd554107135, 64'd554139775, 64'd554123455, 64'd554156095,
      64'd554115295, 64'd554147935, 64'd554131615, 64'd554164255,
      64'd554111215, 64'd554143855,
      64'd554166805, 64'd554116825, 64'd554109685
   };

   // control register file contents
   typedef struct packed {
      logic [CfgWidth-1:0]   header_min;
      logic [CfgWidth-1:0]   header_max;
      logic [CfgWidth-1:0]   zero_min;
      logic [CfgWidth-1:0]   zero_max;
      logic [CfgWidth-1:0]   one_min;
      logic [CfgWidth-1:0]   one_max;
      logic [CountWidth-1:0] bits_per_frame;
   } ipd_cfg_type;

   // classified interval, front to back
   typedef struct packed {
      logic header_hit;
      logic zero_hit;
      logic one_hit;
   } ipd_cmd_type;

   // completed frame, back to response queue
   typedef struct packed {
      logic [FrameWidth-1:0] frame_code;
      logic [KeyWidth-1:0]   key_index;
   } ipd_rsp_type;

endpackage

// ===== src/ir_pulse_distance_decoder.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder: IR remote pulse-distance frame decoder
// Turns falling-edge intervals of an IR receiver into frame codes and keys.
// ----------------------------------------------------------------------------
// One interval request is taken per clock while req_full is low. A classifier
// sorts each interval into header, zero or one windows and drops intervals
// that match none; the rest go through a two-entry command queue to the frame
// assembler, which handles one request per cycle. A completed frame goes
// through a two-entry response queue to the response ports; the assembler
// stalls only when that queue is full, so sustained rate is one interval per
// cycle as long as responses are popped.
// Control registers should be written only while no request is in flight.
module ir_pulse_distance_decoder #(
   parameter int INTERVAL_WIDTH = ipd_pkg::INTERVAL_WIDTH_DEFAULT,
   parameter int CODE_WIDTH     = ipd_pkg::CODE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // interval requests
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [INTERVAL_WIDTH-1:0]      req_interval_us,
   // frame responses
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [ipd_pkg::FrameWidth-1:0] rsp_frame_code,
   output logic [ipd_pkg::KeyWidth-1:0]   rsp_key_index,
   // control registers
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [ipd_pkg::CfgWidth-1:0]   csr_wdata
);
   import ipd_pkg::*;

   ipd_cfg_type cfg;
   ipd_cmd_type front_cmd;
   logic        front_keep;
   ipd_cmd_type back_cmd;
   logic        cmd_empty;
   logic        cmd_pop;
   logic        rsp_full;
   logic        rsp_push;
   ipd_rsp_type back_rsp;
   ipd_rsp_type out_rsp;

   // control registers
   ipd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // classifier
   ipd_front #(.INTERVAL_WIDTH(INTERVAL_WIDTH)) u_front (
      .interval_us (req_interval_us),
      .cfg         (cfg),
      .cmd         (front_cmd),
      .cmd_keep    (front_keep)
   );

   // command queue between classifier and assembler
   ipd_fifo #(.WIDTH($bits(ipd_cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push && front_keep),
      .wr_data (front_cmd),
      .full    (req_full),
      .rd_en   (cmd_pop),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   // frame assembler
   ipd_back #(.CODE_WIDTH(CODE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   // response queue
   ipd_fifo #(.WIDTH($bits(ipd_rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd_en   (rsp_pop),
      .rd_data (out_rsp),
      .empty   (rsp_empty)
   );

   assign rsp_frame_code = out_rsp.frame_code;
   assign rsp_key_index  = out_rsp.key_index;

endmodule

// ===== src/ipd_fifo.sv =====
// ----------------------------------------------------------------------------
// ipd_fifo: small synchronous queue
// Register-based FIFO with full/empty flags; used for the command queue
// between front and back and for the response queue at the output.
// ----------------------------------------------------------------------------
module ipd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/ipd_csr.sv =====
// ----------------------------------------------------------------------------
// ipd_csr: control registers
// Timing windows and frame length, written through a plain write port.
// ----------------------------------------------------------------------------
module ipd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [ipd_pkg::CfgWidth-1:0] csr_wdata,
   output ipd_pkg::ipd_cfg_type         cfg
);
   import ipd_pkg::*;

   ipd_cfg_type cfg_ff, cfg_in;

   assign cfg = cfg_ff;

   // register decode; unlisted indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_HEADER_MIN:     cfg_in.header_min     = csr_wdata;
            REG_HEADER_MAX:     cfg_in.header_max     = csr_wdata;
            REG_ZERO_MIN:       cfg_in.zero_min       = csr_wdata;
            REG_ZERO_MAX:       cfg_in.zero_max       = csr_wdata;
            REG_ONE_MIN:        cfg_in.one_min        = csr_wdata;
            REG_ONE_MAX:        cfg_in.one_max        = csr_wdata;
            REG_BITS_PER_FRAME: cfg_in.bits_per_frame = csr_wdata[CountWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_min     <= HEADER_MIN_RESET;
         cfg_ff.header_max     <= HEADER_MAX_RESET;
         cfg_ff.zero_min       <= ZERO_MIN_RESET;
         cfg_ff.zero_max       <= ZERO_MAX_RESET;
         cfg_ff.one_min        <= ONE_MIN_RESET;
         cfg_ff.one_max        <= ONE_MAX_RESET;
         cfg_ff.bits_per_frame <= BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/ipd_front.sv =====
// ----------------------------------------------------------------------------
// ipd_front: interval classifier
// Compares one interval against the header, zero and one windows and flags
// whether it can have any effect, so idle intervals never reach the queue.
// ----------------------------------------------------------------------------
module ipd_front #(
   parameter int INTERVAL_WIDTH = ipd_pkg::INTERVAL_WIDTH_DEFAULT
) (
   input  logic [INTERVAL_WIDTH-1:0] interval_us,
   input  ipd_pkg::ipd_cfg_type      cfg,
   output ipd_pkg::ipd_cmd_type      cmd,
   output logic                      cmd_keep
);
   import ipd_pkg::*;

   localparam int CmpW = (INTERVAL_WIDTH > CfgWidth) ? INTERVAL_WIDTH : CfgWidth;

   logic [CmpW-1:0] t;

   assign t = CmpW'(interval_us);

   // window compares; an empty window (min above max) never hits
   always_comb begin
      cmd.header_hit = (t >= CmpW'(cfg.header_min)) && (t <= CmpW'(cfg.header_max));
      cmd.zero_hit   = (t >= CmpW'(cfg.zero_min))   && (t <= CmpW'(cfg.zero_max));
      cmd.one_hit    = (t >= CmpW'(cfg.one_min))    && (t <= CmpW'(cfg.one_max));
      cmd_keep       = cmd.header_hit || cmd.zero_hit || cmd.one_hit;
   end

endmodule

// ===== src/ipd_back.sv =====
// ----------------------------------------------------------------------------
// ipd_back: frame assembler
// Applies classified intervals to the armed flag, code shifter and bit
// counter; on the last bit of a frame looks up the key and emits a response.
// ----------------------------------------------------------------------------
module ipd_back #(
   parameter int CODE_WIDTH = ipd_pkg::CODE_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ipd_pkg::ipd_cfg_type cfg,
   input  ipd_pkg::ipd_cmd_type cmd,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output ipd_pkg::ipd_rsp_type rsp
);
   import ipd_pkg::*;

   logic                  header_seen_ff, header_seen_in;
   logic [CODE_WIDTH-1:0] code_ff, code_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  step;
   logic                  armed;
   logic                  got_bit;
   logic [CODE_WIDTH-1:0] code_next;
   logic [CountWidth-1:0] count_next;
   logic                  done;
   logic [KeyWidth-1:0]   key;

   // one request per cycle while the response queue has room
   assign step       = !cmd_empty && !rsp_full;
   assign cmd_pop    = step;
   assign armed      = header_seen_ff || cmd.header_hit;
   assign got_bit    = armed && (cmd.zero_hit || cmd.one_hit);
   // zero window wins where the windows overlap
   assign code_next  = {code_ff[CODE_WIDTH-2:0], !cmd.zero_hit};
   assign count_next = count_ff + 1'b1;
   assign done       = step && got_bit && (count_next == cfg.bits_per_frame);

   // key table match on the completed code
   always_comb begin
      key = KEY_UNKNOWN;
      for (int i = KeyCount - 1; i >= 0; i--) begin
         if (CODE_WIDTH'(KEY_CODES[i]) == code_next) begin
            key = KeyWidth'(i);
         end
      end
   end

   assign rsp_push       = done;
   assign rsp.frame_code = FrameWidth'(code_next);
   assign rsp.key_index  = key;

   // state update
   always_comb begin
      header_seen_in = header_seen_ff;
      code_in        = code_ff;
      count_in       = count_ff;
      if (done) begin
         header_seen_in = 1'b0;
         code_in        = '0;
         count_in       = '0;
      end else if (step) begin
         header_seen_in = armed;
         if (got_bit) begin
            code_in  = code_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_seen_ff <= 1'b0;
         code_ff        <= '0;
         count_ff       <= '0;
      end else begin
         header_seen_ff <= header_seen_in;
         code_ff        <= code_in;
         count_ff       <= count_in;
      end
   end

endmodule

// ===== sim/ipd_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_frame_checker: frame predictor and response checker
// Watches the interval request, control write and frame response channels of
// the IR pulse-distance decoder. Keeps its own copy of the window registers
// and the decoder state, predicts every completed frame and compares each
// popped response against the oldest predicted frame.
// ----------------------------------------------------------------------------
module ipd_frame_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [15:0]                    req_interval_us,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [ipd_pkg::FrameWidth-1:0] rsp_frame_code,
   input  logic [ipd_pkg::KeyWidth-1:0]   rsp_key_index,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [ipd_pkg::CfgWidth-1:0]   csr_wdata,
   output int unsigned                    mismatch_count,
   output int unsigned                    frames_pending
);
   import ipd_pkg::*;

   ipd_cfg_type            window_cfg;
   logic [FrameWidth-1:0]  code_acc;
   logic [CountWidth-1:0]  bits_seen;
   logic                   armed;
   ipd_rsp_type            frames_due [$];

   initial begin
      mismatch_count = 0;
      frames_pending = 0;
   end

   // key table lookup, unknown when no entry matches
   function automatic logic [KeyWidth-1:0] key_of(input logic [FrameWidth-1:0] code);
      for (int i = 0; i < KeyCount; i++) begin
         if (KEY_CODES[i][FrameWidth-1:0] == code) return i[KeyWidth-1:0];
      end
      return KEY_UNKNOWN;
   endfunction

   // one interval through the decoder; queues a frame when the count is reached
   task automatic decode_interval(input logic [15:0] t);
      logic        got_bit;
      ipd_rsp_type frame;
      begin
         got_bit = 1'b0;
         if (t >= window_cfg.header_min && t <= window_cfg.header_max) armed = 1'b1;
         // header may also fall in a bit window: arm first, then decode
         if (armed) begin
            if (t >= window_cfg.zero_min && t <= window_cfg.zero_max) begin
               code_acc = {code_acc[FrameWidth-2:0], 1'b0};
               got_bit  = 1'b1;
            end else if (t >= window_cfg.one_min && t <= window_cfg.one_max) begin
               code_acc = {code_acc[FrameWidth-2:0], 1'b1};
               got_bit  = 1'b1;
            end
         end
         if (got_bit) begin
            bits_seen = bits_seen + 1'b1;
            if (bits_seen == window_cfg.bits_per_frame) begin
               frame.frame_code = code_acc;
               frame.key_index  = key_of(code_acc);
               frames_due.push_back(frame);
               code_acc  = '0;
               bits_seen = '0;
               armed     = 1'b0;
            end
         end
      end
   endtask

   // control register write; unlisted index is dropped
   task automatic apply_write();
      begin
         case (csr_index)
            REG_HEADER_MIN:     window_cfg.header_min = csr_wdata;
            REG_HEADER_MAX:     window_cfg.header_max = csr_wdata;
            REG_ZERO_MIN:       window_cfg.zero_min = csr_wdata;
            REG_ZERO_MAX:       window_cfg.zero_max = csr_wdata;
            REG_ONE_MIN:        window_cfg.one_min = csr_wdata;
            REG_ONE_MAX:        window_cfg.one_max = csr_wdata;
            REG_BITS_PER_FRAME: window_cfg.bits_per_frame = csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   endtask

   // compare a popped response with the oldest predicted frame
   task automatic check_frame();
      ipd_rsp_type want;
      begin
         if (frames_due.size() == 0) begin
            $error("unexpected frame: frame_code %h key_index %0d",
                   rsp_frame_code, rsp_key_index);
            mismatch_count++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_frame_code !== want.frame_code) begin
               $error("frame_code mismatch: expected %h, actual %h",
                      want.frame_code, rsp_frame_code);
               mismatch_count++;
            end
            if (rsp_key_index !== want.key_index) begin
               $error("key_index mismatch: expected %0d, actual %0d",
                      want.key_index, rsp_key_index);
               mismatch_count++;
            end
         end
      end
   endtask

   // channel monitor
   always @(posedge clock) begin
      if (reset) begin
         window_cfg.header_min     = HEADER_MIN_RESET;
         window_cfg.header_max     = HEADER_MAX_RESET;
         window_cfg.zero_min       = ZERO_MIN_RESET;
         window_cfg.zero_max       = ZERO_MAX_RESET;
         window_cfg.one_min        = ONE_MIN_RESET;
         window_cfg.one_max        = ONE_MAX_RESET;
         window_cfg.bits_per_frame = BITS_RESET;
         code_acc  = '0;
         bits_seen = '0;
         armed     = 1'b0;
         frames_due.delete();
      end else begin
         // a response can never stem from a request of the same edge
         if (rsp_pop && !rsp_empty) check_frame();
         if (req_push && !req_full) decode_interval(req_interval_us);
         if (csr_we) apply_write();
      end
      frames_pending = frames_due.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the IR pulse-distance decoder
// Drives interval requests, control writes and response pops with random
// stalls on both sides. A directed run over window edges and overlaps is
// followed by phases of random frames under many window settings; the frame
// checker predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import ipd_pkg::*;

   localparam logic [2:0] RegUnlisted = 3'd7;
   localparam int         PhaseCount  = 12;
   localparam int         PhaseItems  = 56;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [15:0]           req_interval_us = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [FrameWidth-1:0] rsp_frame_code;
   logic [KeyWidth-1:0]   rsp_key_index;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [CfgWidth-1:0]   csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned frames_pending;
   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 61;
   int unsigned total_sent = 0;
   int unsigned phase_items = 0;

   // register values as last written, for shaping the stimulus
   logic [CfgWidth-1:0] cfg_now [7];

   ir_pulse_distance_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_interval_us (req_interval_us),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_frame_code  (rsp_frame_code),
      .rsp_key_index   (rsp_key_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ipd_frame_checker i_frame_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_interval_us (req_interval_us),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_frame_code  (rsp_frame_code),
      .rsp_key_index   (rsp_key_index),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .frames_pending  (frames_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random pops
   always @(negedge clock) begin
      rsp_pop <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // one interval request, held until accepted; idles first by chance
   task automatic push_interval(input logic [15:0] v);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_push <= 1'b0;
            @(negedge clock);
         end
         req_push        <= 1'b1;
         req_interval_us <= v;
         @(posedge clock);
         while (req_full) @(posedge clock);
         total_sent++;
         phase_items++;
         // stall profile: sender light, then receiver light, then none
         if (total_sent < 290) begin
            send_idle_pct = 16;
            recv_idle_pct = 61;
         end else if (total_sent < 580) begin
            send_idle_pct = 61;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [CfgWidth-1:0] val);
      begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         if (idx <= REG_BITS_PER_FRAME) cfg_now[idx] = val;
         @(negedge clock);
         csr_we <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic load_config(input logic [15:0] h_lo, h_hi, z_lo, z_hi, o_lo, o_hi,
                              input logic [15:0] bits);
      begin
         write_reg(REG_HEADER_MIN, h_lo);
         write_reg(REG_HEADER_MAX, h_hi);
         write_reg(REG_ZERO_MIN, z_lo);
         write_reg(REG_ZERO_MAX, z_hi);
         write_reg(REG_ONE_MIN, o_lo);
         write_reg(REG_ONE_MAX, o_hi);
         write_reg(REG_BITS_PER_FRAME, bits);
         write_reg(RegUnlisted, 16'($urandom_range(65535)));
      end
   endtask

   // drain all predicted frames, then let the pipeline settle
   task automatic wait_idle();
      begin
         req_push <= 1'b0;
         while (frames_pending != 0) @(negedge clock);
         repeat (8) @(negedge clock);
      end
   endtask

   // value inside [lo, hi], edges favored; any value for an empty window
   function automatic logic [15:0] pick_in(input logic [15:0] lo, input logic [15:0] hi);
      int unsigned r;
      begin
         if (lo > hi) return 16'($urandom_range(65535));
         r = $urandom_range(9);
         if (r == 0) return lo;
         if (r == 1) return hi;
         return 16'($urandom_range(hi, lo));
      end
   endfunction

   task automatic rand_window(output logic [15:0] lo, output logic [15:0] hi);
      int unsigned a, w;
      begin
         a  = $urandom_range(65535);
         w  = $urandom_range(1500);
         lo = 16'(a);
         hi = (a + w > 65535) ? 16'hFFFF : 16'(a + w);
         if ($urandom_range(7) == 0) {lo, hi} = {hi, lo};
      end
   endtask

   // header then bits from a random or key-table code, with some noise;
   // a broken frame stops short of the configured count
   task automatic send_frame(input bit complete);
      int unsigned nbits, target;
      logic [63:0] content;
      logic        b;
      begin
         nbits   = (cfg_now[REG_BITS_PER_FRAME][5:0] == 0) ? 64
                   : cfg_now[REG_BITS_PER_FRAME][5:0];
         target  = complete ? nbits : $urandom_range(nbits - 1);
         content = {$urandom, $urandom};
         if ($urandom_range(9) < 6)
            content[31:0] = KEY_CODES[$urandom_range(KeyCount - 1)][31:0];
         push_interval(pick_in(cfg_now[REG_HEADER_MIN], cfg_now[REG_HEADER_MAX]));
         for (int i = 0; i < target; i++) begin
            if ($urandom_range(99) < 6) push_interval(16'($urandom_range(65535)));
            if ($urandom_range(99) < 3)
               push_interval(pick_in(cfg_now[REG_HEADER_MIN], cfg_now[REG_HEADER_MAX]));
            b = content[nbits - 1 - i];
            if (b) push_interval(pick_in(cfg_now[REG_ONE_MIN], cfg_now[REG_ONE_MAX]));
            else   push_interval(pick_in(cfg_now[REG_ZERO_MIN], cfg_now[REG_ZERO_MAX]));
         end
      end
   endtask

   // stimulus
   initial begin : stimulus
      int unsigned r;
      logic [15:0] hl, hh, zl, zh, ol, oh;
      cfg_now[REG_HEADER_MIN]     = HEADER_MIN_RESET;
      cfg_now[REG_HEADER_MAX]     = HEADER_MAX_RESET;
      cfg_now[REG_ZERO_MIN]       = ZERO_MIN_RESET;
      cfg_now[REG_ZERO_MAX]       = ZERO_MAX_RESET;
      cfg_now[REG_ONE_MIN]        = ONE_MIN_RESET;
      cfg_now[REG_ONE_MAX]        = ONE_MAX_RESET;
      cfg_now[REG_BITS_PER_FRAME] = 16'(BITS_RESET);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default windows, short frames: edges, unarmed bits, header while armed
      load_config(13400, 13700, 1100, 1250, 2100, 2400, 8);
      push_interval(16'd0);
      push_interval(16'hFFFF);
      push_interval(16'd1100);
      push_interval(16'd13400);
      push_interval(16'd1100);
      push_interval(16'd1250);
      push_interval(16'd2100);
      push_interval(16'd2400);
      push_interval(16'd1099);
      push_interval(16'd2401);
      push_interval(16'd13700);
      push_interval(16'd1251);
      push_interval(16'd2099);
      push_interval(16'd1100);
      push_interval(16'd2100);
      push_interval(16'd2400);
      push_interval(16'd1250);

      // header window overlapping the zero window: arms and decodes at once
      wait_idle();
      load_config(1000, 1300, 1100, 1250, 2100, 2400, 1);
      push_interval(16'd1200);
      push_interval(16'd2200);
      push_interval(16'd1000);
      push_interval(16'd2200);

      // overlapping bit windows: zero wins
      wait_idle();
      load_config(13400, 13700, 1000, 3000, 2000, 4000, 2);
      push_interval(16'd13400);
      push_interval(16'd2500);
      push_interval(16'd3500);

      // random phases, one window setting each
      for (int p = 0; p < PhaseCount; p++) begin
         wait_idle();
         case (p)
            0: load_config(13400, 13700, 1100, 1250, 2100, 2400, 32);
            1: load_config(0, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 1);
            2: load_config(13400, 13700, 1100, 1250, 2100, 2400, 0);
            3: load_config(13400, 13700, 1100, 1250, 2100, 2400, 16'hFFFF);
            4: load_config(13400, 13700, 16'hFFFF, 0, 2100, 2400, 8);
            5: load_config(2000, 2500, 1100, 1250, 2100, 2400, 16);
            6: load_config(13400, 13700, 1000, 3000, 2000, 4000, 12);
            default: begin
               rand_window(hl, hh);
               rand_window(zl, zh);
               rand_window(ol, oh);
               load_config(hl, hh, zl, zh, ol, oh, 16'($urandom_range(24, 1)));
            end
         endcase
         phase_items = 0;
         while (phase_items < PhaseItems) begin
            r = $urandom_range(99);
            if (r < 75)      send_frame(1'b1);
            else if (r < 88) send_frame(1'b0);
            else repeat ($urandom_range(4, 1)) push_interval(16'($urandom_range(65535)));
         end
      end

      wait_idle();
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
